### rtl/direct_mapped_writeback_cache_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the direct mapped write-back cache
// Shared property forms used by the controller and the datapath.
// ----------------------------------------------------------------------------
`ifndef DIRECT_MAPPED_WRITEBACK_CACHE_ASSERT_SVH
`define DIRECT_MAPPED_WRITEBACK_CACHE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define DMWC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cache assertion failed");

// Next-cycle implication, disabled during reset
`define DMWC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cache assertion failed");

`endif

### rtl/dmwc_pkg.sv
// ----------------------------------------------------------------------------
// dmwc_pkg
// Widths, defaults, operation codes and controller/datapath interface types
// for the direct mapped write-back cache.
// ----------------------------------------------------------------------------
package dmwc_pkg;

   // Fixed field widths
   localparam int ADDR_W = 10;
   localparam int DATA_W = 32;

   // Default geometry
   localparam int LINES_DEF     = 4;
   localparam int MEM_WORDS_DEF = 1024;

   // Operation codes
   localparam logic FUNC_READ  = 1'b0;
   localparam logic FUNC_WRITE = 1'b1;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic clear;      // zero one backing memory word
      logic capture;    // take the request transaction
      logic div_q1;     // quotient of address by memory size
      logic div_red;    // reduced address
      logic div_q2;     // quotient of reduced address by line count
      logic div_idx;    // line index
      logic lookup;     // read the indexed line
      logic compare;    // register the hit
      logic writeback;  // write the dirty victim to memory
      logic fetch;      // read the requested word from memory
      logic update;     // write the line
      logic respond;    // load the result register
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic clear_done;
      logic hit;
      logic victim_dirty;
      logic out_free;
   } status_type;

   // Memory size reduces by mask or not at all
   function automatic bit is_fast_red(int m);
      return ((m & (m - 1)) == 0) || (m >= (1 << ADDR_W));
   endfunction

   // Line count reduces by mask
   function automatic bit is_fast_idx(int l);
      return (l & (l - 1)) == 0;
   endfunction

endpackage

### rtl/dmwc_ctrl.sv
// ----------------------------------------------------------------------------
// dmwc_ctrl
// Sequencer for the cache: memory clearing pass, request intake, address
// decode, tag check, victim write-back, fill and result hand-off.
// ----------------------------------------------------------------------------
`include "direct_mapped_writeback_cache_assert.svh"

module dmwc_ctrl
   import dmwc_pkg::*;
#(
   parameter int LINES     = LINES_DEF,
   parameter int MEM_WORDS = MEM_WORDS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   localparam bit FAST_RED = is_fast_red(MEM_WORDS);
   localparam bit FAST_IDX = is_fast_idx(LINES);

   typedef enum logic [10:0] {
      S_CLEAR     = 11'b000_0000_0001,
      S_IDLE      = 11'b000_0000_0010,
      S_DEC_Q1    = 11'b000_0000_0100,
      S_DEC_RED   = 11'b000_0000_1000,
      S_DEC_Q2    = 11'b000_0001_0000,
      S_DEC_IDX   = 11'b000_0010_0000,
      S_LOOKUP    = 11'b000_0100_0000,
      S_COMPARE   = 11'b000_1000_0000,
      S_WRITEBACK = 11'b001_0000_0000,
      S_FETCH     = 11'b010_0000_0000,
      S_UPDATE    = 11'b100_0000_0000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Accept only while idle
   assign req_stall = (state_ff != S_IDLE);

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               if (!FAST_RED) begin
                  state_in = S_DEC_Q1;
               end else if (!FAST_IDX) begin
                  state_in = S_DEC_Q2;
               end else begin
                  state_in = S_LOOKUP;
               end
            end
         end
         S_DEC_Q1: begin
            cmd.div_q1 = 1'b1;
            state_in   = S_DEC_RED;
         end
         S_DEC_RED: begin
            cmd.div_red = 1'b1;
            state_in    = FAST_IDX ? S_LOOKUP : S_DEC_Q2;
         end
         S_DEC_Q2: begin
            cmd.div_q2 = 1'b1;
            state_in   = S_DEC_IDX;
         end
         S_DEC_IDX: begin
            cmd.div_idx = 1'b1;
            state_in    = S_LOOKUP;
         end
         S_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in   = S_COMPARE;
         end
         S_COMPARE: begin
            cmd.compare = 1'b1;
            if (status.hit) begin
               state_in = S_UPDATE;
            end else if (status.victim_dirty) begin
               state_in = S_WRITEBACK;
            end else begin
               state_in = S_FETCH;
            end
         end
         S_WRITEBACK: begin
            cmd.writeback = 1'b1;
            state_in      = S_FETCH;
         end
         S_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = S_UPDATE;
         end
         S_UPDATE: begin
            cmd.update = 1'b1;
            // hold until the result register can take the transaction
            if (status.out_free) begin
               cmd.respond = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   `DMWC_ASSERT_NEXT(a_wb_then_fetch, clock, reset, state_ff == S_WRITEBACK, state_ff == S_FETCH)
   `DMWC_ASSERT_NEXT(a_accept_leaves_idle, clock, reset, req_valid && !req_stall, state_ff != S_IDLE)

endmodule

### rtl/dmwc_dpath.sv
// ----------------------------------------------------------------------------
// dmwc_dpath
// Request registers, address reduction, line store, backing memory and the
// result register of the cache.
// ----------------------------------------------------------------------------
`include "direct_mapped_writeback_cache_assert.svh"

module dmwc_dpath
   import dmwc_pkg::*;
#(
   parameter int LINES     = LINES_DEF,
   parameter int MEM_WORDS = MEM_WORDS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_func,
   input  logic [ADDR_W-1:0] req_address,
   input  logic [DATA_W-1:0] req_write_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [DATA_W-1:0] rsp_read_data,
   output logic              rsp_was_hit,
   output logic              rsp_did_writeback,
   input  cmd_type           cmd,
   output status_type        status
);

   // Geometry
   localparam int MAW      = $clog2(MEM_WORDS);
   localparam int RED_SPAN = (MEM_WORDS < (1 << ADDR_W)) ? MEM_WORDS : (1 << ADDR_W);
   localparam int RED_W    = $clog2(RED_SPAN);
   localparam int IDX_W    = (LINES > 1) ? $clog2(LINES) : 1;

   // Reciprocal constants: exact floor quotient for every operand value
   localparam int     S1   = ADDR_W + $clog2(MEM_WORDS);
   localparam longint R1   = ((longint'(1) << S1) + MEM_WORDS - 1) / MEM_WORDS;
   localparam int     P1_W = 2 * ADDR_W + 2;
   localparam int     W2   = ADDR_W + MAW + 1;
   localparam int     S2   = RED_W + $clog2(LINES);
   localparam longint R2   = ((longint'(1) << S2) + LINES - 1) / LINES;
   localparam int     P2_W = 2 * RED_W + 2;
   localparam int     W3   = RED_W + 10;

   localparam logic [MAW-1:0]   CLR_LAST = MAW'(MEM_WORDS - 1);
   localparam logic [RED_W-1:0] IDX_MASK = RED_W'(LINES - 1);

   // Request registers
   logic              func_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [DATA_W-1:0] wdata_ff;
   logic [ADDR_W-1:0] q1_ff;
   logic [RED_W-1:0]  red_ff;
   logic [RED_W-1:0]  q2_ff;
   logic [IDX_W-1:0]  idx_ff;

   logic [P1_W-1:0]   prod1;
   logic [P2_W-1:0]   prod2;
   logic [RED_W-1:0]  red_fast;
   logic [RED_W-1:0]  red_gen;
   logic [IDX_W-1:0]  idx_gen;

   // Line store
   logic [RED_W-1:0]  line_addr_mem  [LINES];
   logic              line_dirty_mem [LINES];
   logic [DATA_W-1:0] line_word_mem  [LINES];
   logic [LINES-1:0]  line_valid_ff;
   logic [RED_W-1:0]  rd_addr_ff;
   logic              rd_dirty_ff;
   logic [DATA_W-1:0] rd_word_ff;

   // Backing memory
   logic [DATA_W-1:0] mem [MEM_WORDS];
   logic [DATA_W-1:0] mem_rd_ff;
   logic [MAW-1:0]    clr_ff;

   // Per-transaction status and result
   logic              hit_now;
   logic              hit_ff;
   logic              wb_ff;
   logic [DATA_W-1:0] upd_word;
   logic              upd_dirty;
   logic [DATA_W-1:0] last_read_ff;
   logic              rsp_valid_ff;
   logic [DATA_W-1:0] rsp_read_data_ff;
   logic              rsp_was_hit_ff;
   logic              rsp_did_writeback_ff;

   // Address reduction: mask form and reciprocal form
   assign red_fast = RED_W'(req_address);
   assign prod1    = P1_W'(addr_ff) * P1_W'(R1);
   assign red_gen  = RED_W'(W2'(addr_ff) - W2'(q1_ff) * W2'(MEM_WORDS));
   assign prod2    = P2_W'(red_ff) * P2_W'(R2);
   assign idx_gen  = IDX_W'(W3'(red_ff) - W3'(q2_ff) * W3'(LINES));

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff  <= req_func;
         addr_ff  <= req_address;
         wdata_ff <= req_write_data;
         red_ff   <= red_fast;
         idx_ff   <= IDX_W'(red_fast & IDX_MASK);
      end
      if (cmd.div_q1) begin
         q1_ff <= ADDR_W'(prod1 >> S1);
      end
      if (cmd.div_red) begin
         red_ff <= red_gen;
         idx_ff <= IDX_W'(red_gen & IDX_MASK);
      end
      if (cmd.div_q2) begin
         q2_ff <= RED_W'(prod2 >> S2);
      end
      if (cmd.div_idx) begin
         idx_ff <= idx_gen;
      end
   end

   // Line store read and write
   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         rd_addr_ff  <= line_addr_mem[idx_ff];
         rd_dirty_ff <= line_dirty_mem[idx_ff];
         rd_word_ff  <= line_word_mem[idx_ff];
      end
      if (cmd.update) begin
         line_addr_mem[idx_ff]  <= red_ff;
         line_dirty_mem[idx_ff] <= upd_dirty;
         line_word_mem[idx_ff]  <= upd_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_valid_ff <= '0;
      end else if (cmd.update) begin
         line_valid_ff[idx_ff] <= 1'b1;
      end
   end

   // Tag check on the stored reduced address
   assign hit_now             = line_valid_ff[idx_ff] && (rd_addr_ff == red_ff);
   assign status.hit          = hit_now;
   assign status.victim_dirty = line_valid_ff[idx_ff] && rd_dirty_ff;

   always_ff @(posedge clock) begin
      if (cmd.compare) begin
         hit_ff <= hit_now;
         wb_ff  <= 1'b0;
      end else if (cmd.writeback) begin
         wb_ff <= 1'b1;
      end
   end

   // Backing memory: clear sweep, victim write, fill read
   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         mem[clr_ff] <= '0;
      end else if (cmd.writeback) begin
         mem[MAW'(rd_addr_ff)] <= rd_word_ff;
      end
      if (cmd.fetch) begin
         mem_rd_ff <= mem[MAW'(red_ff)];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear) begin
         clr_ff <= clr_ff + MAW'(1);
      end
   end

   assign status.clear_done = (clr_ff == CLR_LAST);

   // Merge hit, fill and write data into the line
   assign upd_word  = (func_ff == FUNC_WRITE) ? wdata_ff : (hit_ff ? rd_word_ff : mem_rd_ff);
   assign upd_dirty = (func_ff == FUNC_WRITE) || (hit_ff && rd_dirty_ff);

   // Result register
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         last_read_ff <= '0;
      end else begin
         if (cmd.respond) begin
            rsp_valid_ff <= 1'b1;
            if (func_ff == FUNC_READ) begin
               last_read_ff <= upd_word;
            end
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         rsp_read_data_ff     <= (func_ff == FUNC_READ) ? upd_word : last_read_ff;
         rsp_was_hit_ff       <= hit_ff;
         rsp_did_writeback_ff <= wb_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_read_data     = rsp_read_data_ff;
   assign rsp_was_hit       = rsp_was_hit_ff;
   assign rsp_did_writeback = rsp_did_writeback_ff;

   `DMWC_ASSERT_IMPL(a_wb_only_on_miss, clock, reset, cmd.writeback, !hit_ff)
   `DMWC_ASSERT_IMPL(a_respond_when_free, clock, reset, cmd.respond, status.out_free)
   `DMWC_ASSERT_IMPL(a_hit_no_wb, clock, reset, cmd.respond && hit_ff, !wb_ff)

endmodule

### rtl/direct_mapped_writeback_cache.sv
// ----------------------------------------------------------------------------
// direct_mapped_writeback_cache
// Direct mapped, write-back, write-allocate cache of one word per line in
// front of an on-chip backing memory.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_*): func (read/write), word address and write data.
//   A transaction is taken when req_valid is high and req_stall is low; the
//   block takes one request at a time and stalls until it is finished.
//   Result channel (rsp_*): read data, hit flag and write-back flag, held in
//   an output register; a new request is taken while a result still waits.
//   Steps from acceptance to result, with power-of-two LINES and a
//   MEM_WORDS that is a power of two or at least 1024: line lookup, tag
//   compare, a victim write-back on a dirty miss, a fill read on any miss,
//   then the line update that loads the result register; the backing
//   memory port (one victim write, one fill read) sets the miss cost. Other
//   MEM_WORDS add the address reduction steps, other LINES the index steps.
//   If rsp_stall holds a previous result, the block waits in its last step
//   with the new result until the output register frees.
//   Reset: lines are invalidated at once; the backing memory is then zeroed
//   one word a cycle through all MEM_WORDS words, with req_stall high throughout.
// ----------------------------------------------------------------------------
module direct_mapped_writeback_cache
   import dmwc_pkg::*;
#(
   parameter int LINES     = LINES_DEF,
   parameter int MEM_WORDS = MEM_WORDS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_func,
   input  logic [ADDR_W-1:0] req_address,
   input  logic [DATA_W-1:0] req_write_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [DATA_W-1:0] rsp_read_data,
   output logic              rsp_was_hit,
   output logic              rsp_did_writeback
);

   cmd_type    cmd;
   status_type status;

   dmwc_ctrl #(
      .LINES     (LINES),
      .MEM_WORDS (MEM_WORDS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   dmwc_dpath #(
      .LINES     (LINES),
      .MEM_WORDS (MEM_WORDS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .req_func          (req_func),
      .req_address       (req_address),
      .req_write_data    (req_write_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_read_data     (rsp_read_data),
      .rsp_was_hit       (rsp_was_hit),
      .rsp_did_writeback (rsp_did_writeback),
      .cmd               (cmd),
      .status            (status)
   );

endmodule

### bench/dmwc_bench_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmwc_bench_pkg
// Scoreboard for the direct mapped write-back cache bench: keeps its own
// copy of the lines and the backing memory, predicts each response from the
// accepted requests and checks the responses in order.
// ----------------------------------------------------------------------------
package dmwc_bench_pkg;
   import dmwc_pkg::*;

   typedef struct {
      logic [DATA_W-1:0] read_data;
      logic              was_hit;
      logic              did_writeback;
   } cache_response_type;

   class cache_scoreboard;
      logic               line_valid [LINES_DEF];
      logic               line_dirty [LINES_DEF];
      int                 line_tag   [LINES_DEF];
      logic [DATA_W-1:0]  line_word  [LINES_DEF];
      logic [DATA_W-1:0]  memory_word[MEM_WORDS_DEF];
      logic [DATA_W-1:0]  last_read_word;
      cache_response_type pending_responses[$];
      int                 mismatches;
      int                 reads;
      int                 writes;
      int                 hits;
      int                 writebacks;

      function new();
         foreach (line_valid[i]) begin
            line_valid[i] = 1'b0;
            line_dirty[i] = 1'b0;
            line_tag[i]   = 0;
            line_word[i]  = '0;
         end
         foreach (memory_word[i]) memory_word[i] = '0;
         last_read_word = '0;
         mismatches     = 0;
         reads          = 0;
         writes         = 0;
         hits           = 0;
         writebacks     = 0;
      endfunction

      // Apply one accepted request to the cache copy and queue its response
      function void note_request(logic func, logic [ADDR_W-1:0] address,
                                 logic [DATA_W-1:0] write_data);
         int                 word_addr;
         int                 index;
         int                 tag;
         int                 victim_addr;
         cache_response_type outcome;
         word_addr = int'(address) % MEM_WORDS_DEF;
         index     = word_addr % LINES_DEF;
         tag       = word_addr / LINES_DEF;
         outcome.was_hit       = line_valid[index] && (line_tag[index] == tag);
         outcome.did_writeback = 1'b0;

         // Miss: write back a dirty victim, then fill the line clean
         if (!outcome.was_hit) begin
            if (line_valid[index] && line_dirty[index]) begin
               victim_addr = (line_tag[index] * LINES_DEF + index) % MEM_WORDS_DEF;
               memory_word[victim_addr] = line_word[index];
               outcome.did_writeback    = 1'b1;
            end
            line_word[index]  = memory_word[word_addr];
            line_tag[index]   = tag;
            line_valid[index] = 1'b1;
            line_dirty[index] = 1'b0;
         end

         if (func == FUNC_WRITE) begin
            line_word[index]  = write_data;
            line_dirty[index] = 1'b1;
            writes++;
         end else begin
            last_read_word = line_word[index];
            reads++;
         end
         outcome.read_data = last_read_word;
         if (outcome.was_hit) hits++;
         if (outcome.did_writeback) writebacks++;
         pending_responses.push_back(outcome);
      endfunction

      // Compare one accepted response with the oldest prediction
      function void check_response(logic [DATA_W-1:0] read_data, logic was_hit,
                                   logic did_writeback);
         cache_response_type want;
         if (pending_responses.size() == 0) begin
            $error("rsp: response with no request outstanding");
            mismatches++;
            return;
         end
         want = pending_responses.pop_front();
         if (read_data !== want.read_data) begin
            $error("rsp_read_data: expected %h, got %h", want.read_data, read_data);
            mismatches++;
         end
         if (was_hit !== want.was_hit) begin
            $error("rsp_was_hit: expected %b, got %b", want.was_hit, was_hit);
            mismatches++;
         end
         if (did_writeback !== want.did_writeback) begin
            $error("rsp_did_writeback: expected %b, got %b", want.did_writeback,
                   did_writeback);
            mismatches++;
         end
      endfunction

      function int outstanding();
         return pending_responses.size();
      endfunction
   endclass

endpackage

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives read and write requests into the direct mapped write-back cache:
// a directed run over hits, clean and dirty misses and the address extremes,
// then random requests biased toward a few conflicting tags, under four
// idling phases. Responses are checked against the scoreboard's prediction.
// ----------------------------------------------------------------------------
module testbench;
   import dmwc_pkg::*;
   import dmwc_bench_pkg::*;

   localparam int RESET_CYCLES     = 8;
   localparam int RANDOM_PER_PHASE = 310;
   localparam int QUIET_LIMIT      = 4000;
   localparam int DRAIN_CYCLES     = 20;

   logic              clock          = 1'b0;
   logic              reset          = 1'b1;
   logic              req_valid      = 1'b0;
   logic              req_stall;
   logic              req_func       = FUNC_READ;
   logic [ADDR_W-1:0] req_address    = '0;
   logic [DATA_W-1:0] req_write_data = '0;
   logic              rsp_valid;
   logic              rsp_stall      = 1'b0;
   logic [DATA_W-1:0] rsp_read_data;
   logic              rsp_was_hit;
   logic              rsp_did_writeback;

   int send_idle_pct  = 0;
   int resp_stall_pct = 0;
   int quiet_cycles   = 0;

   cache_scoreboard scoreboard = new();

   direct_mapped_writeback_cache u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_func          (req_func),
      .req_address       (req_address),
      .req_write_data    (req_write_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_read_data     (rsp_read_data),
      .rsp_was_hit       (rsp_was_hit),
      .rsp_did_writeback (rsp_did_writeback)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Stall the response channel at random
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < resp_stall_pct);
   end

   // Check every accepted response transaction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         scoreboard.check_response(rsp_read_data, rsp_was_hit, rsp_did_writeback);
      end
   end

   // Abort when no transaction moves for too long
   initial begin : watchdog
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
      $display("** direct_mapped_writeback_cache: FAILED **");
      $finish;
   end

   // Present one request from a falling edge and hold it until taken
   task automatic send_request(input logic func, input logic [ADDR_W-1:0] address,
                               input logic [DATA_W-1:0] write_data);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_func       <= func;
      req_address    <= address;
      req_write_data <= write_data;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      scoreboard.note_request(func, address, write_data);
      @(negedge clock);
   endtask

   // Mostly a few tags at each end of memory so lines conflict and go dirty
   task automatic send_random_request();
      logic [ADDR_W-1:0] address;
      logic [7:0]        tag;
      if ($urandom_range(9) < 7) begin
         tag = ($urandom_range(1) != 0) ? 8'($urandom_range(3)) : 8'(252 + $urandom_range(3));
         address = {tag, 2'($urandom_range(3))};
      end else begin
         address = ADDR_W'($urandom);
      end
      send_request(($urandom_range(1) != 0) ? FUNC_WRITE : FUNC_READ, address, $urandom);
   endtask

   initial begin
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      // Directed: hits, clean and dirty misses, address and data extremes
      send_request(FUNC_READ,  10'd0,    32'h0000_0000);
      send_request(FUNC_WRITE, 10'd0,    32'hFFFF_FFFF);
      send_request(FUNC_READ,  10'd0,    32'h0000_0000);
      send_request(FUNC_READ,  10'd4,    32'hFFFF_FFFF);
      send_request(FUNC_READ,  10'd0,    32'h0000_0000);
      send_request(FUNC_WRITE, 10'd1023, 32'h0000_0000);
      send_request(FUNC_WRITE, 10'd1023, 32'hFFFF_FFFF);
      send_request(FUNC_READ,  10'd3,    32'h0000_0000);
      send_request(FUNC_READ,  10'd1023, 32'h0000_0000);
      send_request(FUNC_WRITE, 10'd5,    32'hA5A5_A5A5);
      send_request(FUNC_WRITE, 10'd9,    32'h5A5A_5A5A);
      send_request(FUNC_READ,  10'd5,    32'hFFFF_FFFF);
      send_request(FUNC_READ,  10'd9,    32'h0000_0000);
      send_request(FUNC_WRITE, 10'd1020, 32'h8000_0001);
      send_request(FUNC_READ,  10'd1020, 32'h0000_0000);
      send_request(FUNC_WRITE, 10'd2,    32'h1234_5678);
      send_request(FUNC_WRITE, 10'd1022, 32'h0000_0001);
      send_request(FUNC_READ,  10'd2,    32'h0000_0000);

      // Random: no idling, sender idle, receiver stalling, both
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  resp_stall_pct = 0;  end
            1: begin send_idle_pct = 55; resp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  resp_stall_pct = 55; end
            default: begin send_idle_pct = 37; resp_stall_pct = 37; end
         endcase
         repeat (RANDOM_PER_PHASE) send_random_request();
      end
      req_valid <= 1'b0;

      // Drain outstanding responses, then let the block settle
      while (scoreboard.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d requests: %0d reads, %0d writes, %0d hits, %0d write-backs",
               scoreboard.reads + scoreboard.writes, scoreboard.reads, scoreboard.writes,
               scoreboard.hits, scoreboard.writebacks);
      $display("four idling phases, %0d field mismatches", scoreboard.mismatches);
      if (scoreboard.mismatches == 0) begin
         $display("** direct_mapped_writeback_cache: PASSED **");
      end else begin
         $display("** direct_mapped_writeback_cache: FAILED **");
      end
      $finish;
   end

endmodule

### direct_mapped_writeback_cache.f
+incdir+rtl
rtl/dmwc_pkg.sv
rtl/dmwc_ctrl.sv
rtl/dmwc_dpath.sv
rtl/direct_mapped_writeback_cache.sv
bench/dmwc_bench_pkg.sv
bench/testbench.sv
